FILE: hdl/lpp_pkg.sv
// ----------------------------------------------------------------------------
// lpp_pkg
// Shared types and constants of the LED plan pattern player.
// ----------------------------------------------------------------------------
package lpp_pkg;

  localparam int NUM_LEDS    = 12;
  localparam int MAX_ENTRIES = 16;
  localparam int LED_W       = 4;
  localparam int SLOT_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [11:0] CYC_SLOW = 12'd3000;
  localparam logic [11:0] CYC_FAST = 12'd1000;

  // ceil(2^44 / 3000) and ceil(2^42 / 1000), exact for 32-bit phases
  localparam logic [32:0] PH_RECIP_SLOW = 33'd5864062015;
  localparam logic [32:0] PH_RECIP_FAST = 33'd4398046512;
  // ceil(2^32 / 1500) and ceil(2^32 / 500), exact for 19-bit products
  localparam logic [23:0] SC_RECIP_SLOW = 24'd2863312;
  localparam logic [23:0] SC_RECIP_FAST = 24'd8589935;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_PLAY  = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  localparam logic [1:0] MODE_STABLE  = 2'd0;
  localparam logic [1:0] MODE_BLINK   = 2'd1;
  localparam logic [1:0] MODE_BR_SLOW = 2'd2;
  localparam logic [1:0] MODE_BR_FAST = 2'd3;

  typedef struct packed {
    op_t         op;
    logic [3:0]  slot;
    logic [3:0]  led;
    logic [1:0]  mode;
    logic [15:0] off;
    logic [30:0] dur;
    logic [15:0] per;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [4:0]  cnt;
    logic [7:0]  loops;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

endpackage

FILE: hdl/lpp_front.sv
// ----------------------------------------------------------------------------
// lpp_front
// Accepts requests, classifies them and queues them for the sequencer.
// ----------------------------------------------------------------------------
module lpp_front import lpp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [3:0]  entry_index,
  input  logic [3:0]  led_id,
  input  logic [1:0]  mode,
  input  logic [15:0] offset_ms,
  input  logic [30:0] duration_ms,
  input  logic [15:0] period_ms,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [4:0]  entry_count,
  input  logic [7:0]  loop_count,
  output item_t       head,
  output logic        head_valid,
  input  logic        pop
);

  item_t               q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  item_t               item;
  logic                drop;
  logic                push;
  logic                do_pop;

  always_comb begin
    item.op    = op_t'(opcode);
    item.slot  = entry_index;
    item.led   = led_id;
    item.mode  = mode;
    item.off   = offset_ms;
    item.dur   = duration_ms;
    item.per   = period_ms;
    item.red   = red;
    item.green = green;
    item.blue  = blue;
    item.cnt   = (entry_count > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : entry_count;
    item.loops = loop_count;
  end

  // writes to a slot beyond the table never reach the sequencer
  assign drop       = (op_t'(opcode) == OP_WRITE) &&
                      ({1'b0, entry_index} >= 5'(MAX_ENTRIES));
  assign in_stall   = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign push       = in_valid && !in_stall && !drop;
  assign head_valid = (count != '0);
  assign do_pop     = pop && head_valid;
  assign head       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        q[wr_ptr] <= item;
        wr_ptr    <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/lpp_div.sv
// ----------------------------------------------------------------------------
// lpp_div
// Restoring divider for the blink period, one quotient bit per cycle (32 steps).
// ----------------------------------------------------------------------------
module lpp_div import lpp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy;
  logic [5:0]  steps;
  logic [15:0] rem;
  logic [31:0] dvd;
  logic [15:0] divisor;
  logic        done;
  logic [16:0] trial;
  logic        ge;

  assign trial = {rem, dvd[31]};
  assign ge    = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        rem   <= ge ? 16'(trial - {1'b0, divisor}) : trial[15:0];
        dvd   <= {dvd[30:0], ge};
        steps <= steps - 1'b1;
        if (steps == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy    <= 1'b1;
        divisor <= req.divisor;
        rem     <= '0;
        dvd     <= req.dividend;
        steps   <= 6'd32;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = dvd;

endmodule

FILE: hdl/lpp_back.sv
// ----------------------------------------------------------------------------
// lpp_back
// Sequencer: plan table, timing, frame rendering and frame output.
// ----------------------------------------------------------------------------
module lpp_back import lpp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  item_t       head,
  input  logic        head_valid,
  output logic        pop,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data,
  output div_req_t    div_req,
  input  div_rsp_t    div_rsp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  led_index,
  output logic [23:0] grb_word,
  output logic        last_of_frame
);

  typedef enum logic [3:0] {
    S_IDLE, S_PLEN, S_MUL, S_CHK, S_ENT, S_BLINK, S_BRE, S_MOD, S_SCST, S_SCW, S_CMP,
    S_EMIT
  } state_t;

  typedef logic [NUM_LEDS-1:0][23:0] frame_t;

  state_t            state;
  logic [46:0]       ent_timing [MAX_ENTRIES];
  logic [45:0]       ent_look   [MAX_ENTRIES];
  logic [4:0]        active_count;
  logic              playing;
  logic [31:0]       tick_count;
  logic [31:0]       plan_length;
  logic [7:0]        loops_done;
  logic [7:0]        loops_wanted;
  logic [7:0]        tick_ms;
  logic [39:0]       now;
  frame_t            frame;
  frame_t            shown;
  logic [4:0]        ei;
  logic [LED_W-1:0]  oi;
  logic [1:0]        ch_sel;
  logic [10:0]       ebr;
  logic [11:0]       br_q;
  logic [18:0]       sc_x;
  logic [7:0]        sc_r;
  logic [7:0]        sc_g;
  logic              o_valid;
  logic [3:0]        o_led;
  logic [23:0]       o_grb;
  logic              o_last;

  logic [SLOT_W-1:0] idx;
  logic [15:0]       e_off;
  logic [30:0]       e_dur;
  logic [31:0]       e_len;
  logic [3:0]        e_led;
  logic [1:0]        e_mode;
  logic [15:0]       e_per;
  logic [7:0]        e_r;
  logic [7:0]        e_g;
  logic [7:0]        e_b;
  logic [23:0]       e_grb;
  logic              in_rng;
  logic [39:0]       rel_full;
  logic              is_slow;
  logic [11:0]       cyc;
  logic [32:0]       ph_recip;
  logic [64:0]       ph_prod;
  logic [11:0]       ph_quo;
  logic [23:0]       qc;
  logic [11:0]       e_rem;
  logic [10:0]       e_fold;
  logic [7:0]        ch_val;
  logic [23:0]       sc_recip;
  logic [42:0]       sc_prod;
  logic [7:0]        sc_q;
  logic              last_ent;
  logic [7:0]        loops_inc;

  assign idx      = ei[SLOT_W-1:0];
  assign e_off    = ent_timing[idx][46:31];
  assign e_dur    = ent_timing[idx][30:0];
  assign e_len    = {16'd0, e_off} + {1'b0, e_dur};
  assign e_led    = ent_look[idx][45:42];
  assign e_mode   = ent_look[idx][41:40];
  assign e_per    = ent_look[idx][39:24];
  assign e_r      = ent_look[idx][23:16];
  assign e_g      = ent_look[idx][15:8];
  assign e_b      = ent_look[idx][7:0];
  assign e_grb    = {e_g, e_r, e_b};
  assign in_rng   = ({1'b0, e_led} < 5'(NUM_LEDS)) && (now >= {24'd0, e_off}) &&
                    (now <= {8'd0, e_len});
  assign rel_full = now - {24'd0, e_off};
  assign is_slow  = (e_mode == MODE_BR_SLOW);
  assign cyc      = is_slow ? CYC_SLOW : CYC_FAST;

  // breathing phase: quotient by reciprocal, low bits give the remainder
  assign ph_recip = is_slow ? PH_RECIP_SLOW : PH_RECIP_FAST;
  assign ph_prod  = 65'(rel_full[31:0]) * 65'(ph_recip);
  assign ph_quo   = is_slow ? ph_prod[55:44] : ph_prod[53:42];
  assign qc       = br_q * cyc;
  assign e_rem    = rel_full[11:0] - qc[11:0];
  assign e_fold   = (e_rem > (cyc >> 1)) ? 11'(cyc - e_rem) : e_rem[10:0];

  // channel scaling: floor(ch * e / (cyc / 2))
  assign sc_recip = is_slow ? SC_RECIP_SLOW : SC_RECIP_FAST;
  assign sc_prod  = 43'(sc_x) * 43'(sc_recip);
  assign sc_q     = sc_prod[39:32];

  assign last_ent  = ((ei + 5'd1) >= active_count);
  assign loops_inc = loops_done + 8'd1;
  assign pop       = (state == S_IDLE) && head_valid;

  always_comb begin
    case (ch_sel)
      2'd0:    ch_val = e_r;
      2'd1:    ch_val = e_g;
      default: ch_val = e_b;
    endcase
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = rel_full[31:0];
    div_req.divisor  = e_per;
    if (state == S_ENT && in_rng && e_mode == MODE_BLINK) begin
      div_req.start = (e_per != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      active_count <= '0;
      playing      <= 1'b0;
      tick_count   <= '0;
      plan_length  <= '0;
      loops_done   <= '0;
      loops_wanted <= 8'd1;
      tick_ms      <= 8'd15;
      shown        <= '0;
      shown[0]     <= 24'h000100;
      o_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        tick_ms <= cfg_data;
      end
      if (o_valid && !out_stall && state != S_EMIT) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (head_valid) begin
            unique case (head.op)
              OP_WRITE: begin
                ent_timing[head.slot[SLOT_W-1:0]] <= {head.off, head.dur};
                ent_look[head.slot[SLOT_W-1:0]]   <= {head.led, head.mode, head.per,
                                                      head.red, head.green, head.blue};
              end
              OP_STOP: begin
                playing      <= 1'b0;
                tick_count   <= '0;
                plan_length  <= '0;
                active_count <= '0;
                frame        <= '0;
                state        <= S_CMP;
              end
              OP_PLAY: begin
                playing      <= 1'b0;
                tick_count   <= '0;
                plan_length  <= '0;
                frame        <= '0;
                loops_done   <= '0;
                loops_wanted <= head.loops;
                active_count <= head.cnt;
                ei           <= '0;
                state        <= (head.cnt == '0) ? S_CMP : S_PLEN;
              end
              OP_TICK: begin
                if (playing) begin
                  tick_count <= tick_count + 32'd1;
                  state      <= S_MUL;
                end
              end
              default: ;
            endcase
          end
        end
        S_PLEN: begin
          if (e_len > plan_length) begin
            plan_length <= e_len;
          end
          ei <= ei + 5'd1;
          if (last_ent) begin
            playing <= 1'b1;
            state   <= S_CMP;
          end
        end
        S_MUL: begin
          now   <= 40'(tick_count) * 40'(tick_ms);
          state <= S_CHK;
        end
        S_CHK: begin
          if (now > {8'd0, plan_length}) begin
            loops_done <= loops_inc;
            if (loops_inc == loops_wanted) begin
              playing      <= 1'b0;
              tick_count   <= '0;
              plan_length  <= '0;
              active_count <= '0;
              frame        <= '0;
              state        <= S_CMP;
            end else begin
              tick_count <= '0;
              state      <= S_IDLE;
            end
          end else begin
            frame <= '0;
            ei    <= '0;
            state <= S_ENT;
          end
        end
        S_ENT: begin
          if (in_rng && (e_mode == MODE_BLINK) && (e_per != '0)) begin
            state <= S_BLINK;
          end else if (in_rng && (e_mode == MODE_BR_SLOW || e_mode == MODE_BR_FAST)) begin
            state <= S_BRE;
          end else begin
            if (in_rng) begin
              frame[e_led] <= e_grb;
            end
            ei    <= ei + 5'd1;
            state <= last_ent ? S_CMP : S_ENT;
          end
        end
        S_BLINK: begin
          if (div_rsp.done) begin
            frame[e_led] <= div_rsp.quo[0] ? 24'd0 : e_grb;
            ei           <= ei + 5'd1;
            state        <= last_ent ? S_CMP : S_ENT;
          end
        end
        S_BRE: begin
          br_q  <= ph_quo;
          state <= S_MOD;
        end
        S_MOD: begin
          ebr    <= e_fold;
          ch_sel <= 2'd0;
          state  <= S_SCST;
        end
        S_SCST: begin
          sc_x  <= 19'(ch_val) * 19'(ebr);
          state <= S_SCW;
        end
        S_SCW: begin
          case (ch_sel)
            2'd0: begin
              sc_r   <= sc_q;
              ch_sel <= 2'd1;
              state  <= S_SCST;
            end
            2'd1: begin
              sc_g   <= sc_q;
              ch_sel <= 2'd2;
              state  <= S_SCST;
            end
            default: begin
              frame[e_led] <= {sc_g, sc_r, sc_q};
              ei           <= ei + 5'd1;
              state        <= last_ent ? S_CMP : S_ENT;
            end
          endcase
        end
        S_CMP: begin
          if (frame != shown) begin
            shown <= frame;
            oi    <= '0;
            state <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!o_valid || !out_stall) begin
            o_valid <= 1'b1;
            o_led   <= 4'(oi);
            o_grb   <= shown[oi];
            o_last  <= (oi == LED_W'(NUM_LEDS - 1));
            if (oi == LED_W'(NUM_LEDS - 1)) begin
              state <= S_IDLE;
            end else begin
              oi <= oi + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = o_valid;
  assign led_index     = o_led;
  assign grb_word      = o_grb;
  assign last_of_frame = o_last;

endmodule

FILE: hdl/led_plan_pattern_player.sv
// ----------------------------------------------------------------------------
// led_plan_pattern_player
// Plays an LED plan of up to 16 timed entries and emits changed frames.
// ----------------------------------------------------------------------------
// Requests enter a four-deep queue and are carried out one at a time by the
// sequencer. Write entry stores one table slot, stop clears the frame, and
// play clears the frame and scans the entries for the plan length. A tick
// makes one pass over the entries: a stable entry is set directly, an unlit
// one skipped, a blink entry waits on the shared 32-step bit-serial divider
// for the period, and a breathing entry uses reciprocal multiplications for
// the phase and each colour channel. A changed frame adds 12 output words,
// one per cycle while out_stall is low. tick_ms is written through cfg_write
// and cfg_data and is used by each tick that reaches its multiply afterwards.
module led_plan_pattern_player import lpp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [3:0]  entry_index,
  input  logic [3:0]  led_id,
  input  logic [1:0]  mode,
  input  logic [15:0] offset_ms,
  input  logic [30:0] duration_ms,
  input  logic [15:0] period_ms,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [4:0]  entry_count,
  input  logic [7:0]  loop_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  led_index,
  output logic [23:0] grb_word,
  output logic        last_of_frame
);

  item_t    head;
  logic     head_valid;
  logic     pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  lpp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .entry_index (entry_index),
    .led_id      (led_id),
    .mode        (mode),
    .offset_ms   (offset_ms),
    .duration_ms (duration_ms),
    .period_ms   (period_ms),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .entry_count (entry_count),
    .loop_count  (loop_count),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop)
  );

  lpp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  lpp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .div_req       (div_req),
    .div_rsp       (div_rsp),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .led_index     (led_index),
    .grb_word      (grb_word),
    .last_of_frame (last_of_frame)
  );

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_frame |-> led_index == 4'(NUM_LEDS - 1))
    else $error("last word not at final led");

  a_frame_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_frame |=> out_valid)
    else $error("frame interrupted");

  a_led_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_frame |=> led_index == $past(led_index) + 4'd1)
    else $error("led words out of order");

endmodule
